// File: design/tsg_pkg.sv
// Shared constants for the triangle shape gradient pipeline.
// No dependencies.
package tsg_pkg;

    localparam int COORD_WIDTH_DEF     = 24;
    localparam int COORD_FRAC_BITS_DEF = 12;
    localparam int GRAD_FRAC_BITS      = 16;
    localparam int RECIP_FRAC_BITS     = 32;
    localparam int AREA_WIDTH          = 52;
    localparam int GRAD_WIDTH          = 32;
    localparam int NUM_LANES           = 6;
    // shift amounts at or above this give a zero magnitude
    localparam int SHIFT_LIMIT         = 62;

endpackage

// File: design/triangle_shape_gradients.sv
// Throughput: one triangle per cycle while the output is not stalled (m_ready high or
// the output stage empty); the cost is set by the 33-stage restoring reciprocal divider
// and the six lane multipliers.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all stage valid bits; data regs are not reset.
// Uses tsg_pkg.
module triangle_shape_gradients #(
    parameter int COORD_WIDTH     = tsg_pkg::COORD_WIDTH_DEF,
    parameter int COORD_FRAC_BITS = tsg_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_WIDTH-1:0]        s_ax,
    input  logic signed [COORD_WIDTH-1:0]        s_ay,
    input  logic signed [COORD_WIDTH-1:0]        s_bx,
    input  logic signed [COORD_WIDTH-1:0]        s_by_coord,
    input  logic signed [COORD_WIDTH-1:0]        s_cx,
    input  logic signed [COORD_WIDTH-1:0]        s_cy,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [tsg_pkg::AREA_WIDTH-1:0] m_signed_area,
    output logic signed [tsg_pkg::GRAD_WIDTH-1:0] m_grad_x0,
    output logic signed [tsg_pkg::GRAD_WIDTH-1:0] m_grad_x1,
    output logic signed [tsg_pkg::GRAD_WIDTH-1:0] m_grad_x2,
    output logic signed [tsg_pkg::GRAD_WIDTH-1:0] m_grad_y0,
    output logic signed [tsg_pkg::GRAD_WIDTH-1:0] m_grad_y1,
    output logic signed [tsg_pkg::GRAD_WIDTH-1:0] m_grad_y2,
    output logic                                 m_degenerate
);

    localparam int W    = COORD_WIDTH;
    localparam int DFW  = W + 1;
    localparam int PW   = 2 * W + 1;
    localparam int DW   = 2 * W + 3;
    localparam int NORM = $clog2(DW);
    localparam int QB   = tsg_pkg::RECIP_FRAC_BITS + 1;
    localparam int MW   = DFW + QB;
    localparam int SW   = $clog2(DW + tsg_pkg::GRAD_FRAC_BITS + 1) + 2;
    localparam int SOFF = DW - 1 + tsg_pkg::GRAD_FRAC_BITS - COORD_FRAC_BITS;
    localparam int NL   = tsg_pkg::NUM_LANES;
    localparam int GW   = tsg_pkg::GRAD_WIDTH;
    localparam int AW   = tsg_pkg::AREA_WIDTH;
    localparam int EW   = (DW > AW) ? DW : AW;
    localparam int NC   = NORM + QB + 4;
    localparam int IDX_MUL = NORM + QB + 1;
    localparam int IDX_RND = NORM + QB + 2;
    localparam int IDX_OUT = NORM + QB + 3;

    // front stages: differences, products, area
    logic                  v1_reg, v2_reg, v3_reg;
    logic signed [W-1:0]   x1_reg [3];
    logic signed [DFW-1:0] l1_reg [NL];
    logic signed [DFW-1:0] l2_reg [NL];
    logic signed [DFW-1:0] l3_reg [NL];
    logic signed [PW-1:0]  p2_reg [3];
    logic signed [DW-1:0]  a3_reg;

    // common payload from the abs stage to the output
    logic                  cv_reg [NC];
    logic signed [DW-1:0]  ca_reg [NC];
    logic                  cn_reg [NC];
    logic                  cz_reg [NC];
    logic signed [DFW-1:0] cl_reg [NC][NL];

    logic adv;
    assign adv     = !cv_reg[IDX_OUT] || m_ready;
    assign s_ready = adv;

    logic [DW-1:0]   mn_reg [NORM+1];
    logic [NORM-1:0] lz_reg [NORM+1];

    logic [DW:0]          rem_reg [QB];
    logic [QB-1:0]        q_reg   [QB];
    logic [DW-1:0]        dv_reg  [QB];
    logic signed [SW-1:0] s_reg   [QB];

    logic [MW-1:0]        prod_reg [NL];
    logic signed [SW-1:0] s_mul_reg, s_rnd_reg;
    logic [63:0]          sum_reg  [NL];
    logic signed [GW-1:0] grad_reg [NL];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i < NC; i++) cv_reg[i] <= 1'b0;
        end else if (adv) begin
            v1_reg    <= s_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            cv_reg[0] <= v3_reg;
            for (int i = 1; i < NC; i++) cv_reg[i] <= cv_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg[0] <= s_ax;
            x1_reg[1] <= s_bx;
            x1_reg[2] <= s_cx;
            // lanes 0..2 feed grad_x (y differences), 3..5 feed grad_y
            l1_reg[0] <= DFW'(s_by_coord) - DFW'(s_cy);
            l1_reg[1] <= DFW'(s_cy) - DFW'(s_ay);
            l1_reg[2] <= DFW'(s_ay) - DFW'(s_by_coord);
            l1_reg[3] <= DFW'(s_cx) - DFW'(s_bx);
            l1_reg[4] <= DFW'(s_ax) - DFW'(s_cx);
            l1_reg[5] <= DFW'(s_bx) - DFW'(s_ax);
            for (int i = 0; i < 3; i++) p2_reg[i] <= x1_reg[i] * l1_reg[i];
            l2_reg <= l1_reg;
            a3_reg <= DW'(p2_reg[0]) + DW'(p2_reg[1]) + DW'(p2_reg[2]);
            l3_reg <= l2_reg;

            ca_reg[0] <= a3_reg;
            cn_reg[0] <= a3_reg[DW-1];
            cz_reg[0] <= (a3_reg == '0);
            cl_reg[0] <= l3_reg;
            mn_reg[0] <= a3_reg[DW-1] ? DW'(-a3_reg) : DW'(a3_reg);
            lz_reg[0] <= '0;
            for (int i = 1; i < NC; i++) begin
                ca_reg[i] <= ca_reg[i-1];
                cn_reg[i] <= cn_reg[i-1];
                cz_reg[i] <= cz_reg[i-1];
                cl_reg[i] <= cl_reg[i-1];
            end
        end
    end

    // leading-zero normalize, one power-of-two step per stage
    for (genvar j = 1; j <= NORM; j++) begin : g_norm
        localparam int K = 1 << (NORM - j);
        logic top_zero;
        assign top_zero = ((mn_reg[j-1] >> (DW - K)) == '0);
        always_ff @(posedge aclk) begin
            if (adv) begin
                mn_reg[j] <= top_zero ? (mn_reg[j-1] << K) : mn_reg[j-1];
                lz_reg[j] <= top_zero ? lz_reg[j-1] + NORM'(K) : lz_reg[j-1];
            end
        end
    end

    // restoring divide: R = floor(2^(32+DW-1) / mn), one quotient bit per stage
    for (genvar t = 0; t < QB; t++) begin : g_div
        logic [DW:0]          r_in;
        logic [QB-1:0]        q_in;
        logic [DW-1:0]        dvs;
        logic signed [SW-1:0] s_in;
        logic                 ge;
        if (t == 0) begin : g_first
            assign r_in = {2'b01, {(DW-1){1'b0}}};
            assign q_in = '0;
            assign dvs  = mn_reg[NORM];
            assign s_in = SW'(SOFF) - SW'({1'b0, lz_reg[NORM]});
        end else begin : g_next
            assign r_in = {rem_reg[t-1][DW-1:0], 1'b0};
            assign q_in = {q_reg[t-1][QB-2:0], 1'b0};
            assign dvs  = dv_reg[t-1];
            assign s_in = s_reg[t-1];
        end
        assign ge = (r_in >= {1'b0, dvs});
        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[t] <= ge ? (r_in - {1'b0, dvs}) : r_in;
                q_reg[t]   <= {q_in[QB-1:1], ge};
                dv_reg[t]  <= dvs;
                s_reg[t]   <= s_in;
            end
        end
    end

    logic [5:0] sh_rnd, sh_out;
    logic       s_ok_rnd, s_ok_out;
    assign s_ok_rnd = (s_mul_reg >= SW'(1)) && (s_mul_reg < SW'(tsg_pkg::SHIFT_LIMIT));
    assign sh_rnd   = s_ok_rnd ? s_mul_reg[5:0] : 6'd0;
    assign s_ok_out = (s_rnd_reg >= SW'(1)) && (s_rnd_reg < SW'(tsg_pkg::SHIFT_LIMIT));
    assign sh_out   = s_ok_out ? s_rnd_reg[5:0] : 6'd0;

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_mul_reg <= s_reg[QB-1];
            s_rnd_reg <= s_mul_reg;
            for (int k = 0; k < NL; k++) begin
                prod_reg[k] <= MW'(cl_reg[IDX_MUL-1][k][DFW-1]
                                   ? DFW'(-cl_reg[IDX_MUL-1][k])
                                   : DFW'(cl_reg[IDX_MUL-1][k])) * MW'(q_reg[QB-1]);
                sum_reg[k]  <= 64'(prod_reg[k]) + ((64'd1 << sh_rnd) >> 1);
            end
        end
    end

    logic [63:0] mag [NL];
    logic signed [GW-1:0] grad_next [NL];
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            mag[k] = sum_reg[k] >> sh_out;
            if (cz_reg[IDX_RND] || cl_reg[IDX_RND][k] == '0) begin
                grad_next[k] = '0;
            end else if (s_rnd_reg <= SW'(0) || (s_ok_out && mag[k][63:31] != '0)) begin
                grad_next[k] = (cl_reg[IDX_RND][k][DFW-1] ^ cn_reg[IDX_RND])
                               ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
            end else if (!s_ok_out) begin
                grad_next[k] = '0;
            end else if (cl_reg[IDX_RND][k][DFW-1] ^ cn_reg[IDX_RND]) begin
                grad_next[k] = -$signed(mag[k][GW-1:0]);
            end else begin
                grad_next[k] = $signed(mag[k][GW-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) grad_reg <= grad_next;
    end

    logic signed [EW-1:0] area_ext;
    assign area_ext      = EW'(ca_reg[IDX_OUT]);
    assign m_valid       = cv_reg[IDX_OUT];
    assign m_signed_area = area_ext[AW-1:0];
    assign m_degenerate  = cz_reg[IDX_OUT];
    assign m_grad_x0     = grad_reg[0];
    assign m_grad_x1     = grad_reg[1];
    assign m_grad_x2     = grad_reg[2];
    assign m_grad_y0     = grad_reg[3];
    assign m_grad_y1     = grad_reg[4];
    assign m_grad_y2     = grad_reg[5];

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_signed_area == '0 && m_grad_x0 == '0 &&
        m_grad_x1 == '0 && m_grad_x2 == '0 && m_grad_y0 == '0 &&
        m_grad_y1 == '0 && m_grad_y2 == '0)
        else $error("degenerate result with nonzero fields");

    a_area_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |-> ca_reg[IDX_OUT] != '0)
        else $error("nondegenerate result with zero area");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule
